[rtl/core/blstk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blstk_pkg
// Shared codes, widths and item types for the bounded lifo stack.
// ----------------------------------------------------------------------------
package blstk_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CAP_W  = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_SHOW = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_SHOW,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic signed [WORD_W-1:0] value;
  } cmd_item_t;

endpackage

[rtl/core/bounded_lifo_stack.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_lifo_stack
// Bounded last-in first-out stack of signed 32-bit words.
//
// Input channel in_valid/in_stall carries cmd (push, pop, display) and
// push_value. Output channel out_valid/out_stall carries one result per
// push, pop or unused command, and one result per stored entry for a
// display (top to bottom, last on the bottom entry); a display of an
// empty stack gives a single empty-status result.
// cfg_wen/cfg_wdata write the capacity, clamped to 1..DEPTH.
// An accepted item is registered in the front stage, queued and taken by
// the back stage into the result register. Push, unused command, refused
// pop and empty display go one item per cycle while out_stall is low; a
// pop or a non-empty display holds the back stage in its read states, set by
// the registered read of the entry memory, until its results are loaded.
// Reset empties the stack and sets the capacity to 64; memory contents
// are not cleared. While out_stall is high the result register holds, the
// back stage waits, the two-entry queue fills and in_stall rises.
// ----------------------------------------------------------------------------
module bounded_lifo_stack import blstk_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wen,
  input  logic [CAP_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               cmd,
  input  logic signed [WORD_W-1:0] push_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] data_value,
  output logic signed [WORD_W-1:0] top_value,
  output logic [1:0]               status,
  output logic                     is_empty,
  output logic                     is_full,
  output logic                     last
);

  logic      fr_valid;
  cmd_item_t fr_item;
  logic      q_ready;
  logic      q_valid;
  logic      q_take;
  cmd_item_t q_item;

  blstk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .push_value (push_value),
    .fr_valid   (fr_valid),
    .fr_item    (fr_item),
    .q_ready    (q_ready)
  );

  blstk_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_valid),
    .wr_ready (q_ready),
    .wr_item  (fr_item),
    .rd_valid (q_valid),
    .rd_take  (q_take),
    .rd_item  (q_item)
  );

  blstk_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_take     (q_take),
    .q_item     (q_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_value (data_value),
    .top_value  (top_value),
    .status     (status),
    .is_empty   (is_empty),
    .is_full    (is_full),
    .last       (last)
  );

endmodule

[rtl/core/blstk_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blstk_front
// Input stage: takes command items, decodes them and hands them to the queue.
// ----------------------------------------------------------------------------
module blstk_front import blstk_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               cmd,
  input  logic signed [WORD_W-1:0] push_value,
  output logic                     fr_valid,
  output cmd_item_t                fr_item,
  input  logic                     q_ready
);

  op_t op_dec;

  always_comb begin
    case (cmd)
      CMD_PUSH: op_dec = OP_PUSH;
      CMD_POP:  op_dec = OP_POP;
      CMD_SHOW: op_dec = OP_SHOW;
      default:  op_dec = OP_NOP;
    endcase
  end

  assign in_stall = fr_valid & ~q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (!fr_valid || q_ready) begin
      fr_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((!fr_valid || q_ready) && in_valid) begin
      fr_item.op    <= op_dec;
      fr_item.value <= push_value;
    end
  end

endmodule

[rtl/core/blstk_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blstk_queue
// Two-entry queue of decoded items between the front and the back.
// ----------------------------------------------------------------------------
module blstk_queue import blstk_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  cmd_item_t wr_item,
  output logic      rd_valid,
  input  logic      rd_take,
  output cmd_item_t rd_item
);

  cmd_item_t  slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_item  = slot[rd_ptr];
  assign do_wr    = wr_valid & wr_ready;
  assign do_rd    = rd_take & rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      case ({do_wr, do_rd})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot[wr_ptr] <= wr_item;
    end
  end

endmodule

[rtl/core/blstk_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blstk_back
// Execution stage: entry memory, count, top register and result register.
// ----------------------------------------------------------------------------
module blstk_back import blstk_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wen,
  input  logic [CAP_W-1:0]         cfg_wdata,
  input  logic                     q_valid,
  output logic                     q_take,
  input  cmd_item_t                q_item,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] data_value,
  output logic signed [WORD_W-1:0] top_value,
  output logic [1:0]               status,
  output logic                     is_empty,
  output logic                     is_full,
  output logic                     last
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_RD,
    S_SHOW_RD,
    S_SHOW_EMIT
  } state_t;

  state_t                   state;
  logic [CAP_W-1:0]         cap;
  logic [CW-1:0]            count;
  logic signed [WORD_W-1:0] top;
  logic [AW-1:0]            idx;

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rd_data;
  logic [AW-1:0]            rd_addr;
  logic                     mem_we;

  logic [EW-1:0]            eff;
  logic [EW-1:0]            cap_ext;
  logic [EW-1:0]            cnt_ext;
  logic [EW-1:0]            cnt_p1_ext;
  logic [EW-1:0]            cnt_m1_ext;
  logic [CW-1:0]            cnt_m1;
  logic [CW-1:0]            cnt_m2;
  logic                     empty_now;
  logic                     full_now;
  logic                     full_inc;
  logic                     full_dec;
  logic signed [WORD_W-1:0] top_cur;
  logic                     can_load;
  logic                     res_load;

  // effective capacity, clamped to 1..DEPTH
  assign cap_ext    = EW'(cap);
  assign eff        = (cap == '0) ? EW'(1) :
                      ((cap_ext > EW'(DEPTH)) ? EW'(DEPTH) : cap_ext);
  assign cnt_m1     = count - CW'(1);
  assign cnt_m2     = count - CW'(2);
  assign cnt_ext    = EW'(count);
  assign cnt_p1_ext = cnt_ext + EW'(1);
  assign cnt_m1_ext = EW'(cnt_m1);
  assign empty_now  = (count == '0);
  assign full_now   = (cnt_ext >= eff);
  assign full_inc   = (cnt_p1_ext >= eff);
  assign full_dec   = (cnt_m1_ext >= eff);
  assign top_cur    = empty_now ? '0 : top;

  assign can_load = ~out_valid | ~out_stall;
  assign q_take   = (state == S_IDLE) & q_valid & can_load;
  assign mem_we   = q_take & (q_item.op == OP_PUSH) & ~full_now;
  assign rd_addr  = ((state == S_IDLE) || (state == S_POP_RD)) ? cnt_m2[AW-1:0] : idx;

  // result register loads this cycle
  assign res_load = (q_take &&
                     !(((q_item.op == OP_POP) || (q_item.op == OP_SHOW)) && !empty_now))
                    || (((state == S_POP_RD) || (state == S_SHOW_EMIT)) && can_load);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[AW-1:0]] <= q_item.value;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cap       <= CAP_RESET;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wen) cap <= cfg_wdata;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_take) begin
            case (q_item.op)
              OP_PUSH: begin
                data_value <= '0;
                last       <= 1'b1;
                if (full_now) begin
                  top_value <= top_cur;
                  status    <= ST_FULL;
                  is_empty  <= empty_now;
                  is_full   <= 1'b1;
                end else begin
                  count     <= count + CW'(1);
                  top       <= q_item.value;
                  top_value <= q_item.value;
                  status    <= ST_DONE;
                  is_empty  <= 1'b0;
                  is_full   <= full_inc;
                end
              end
              OP_POP, OP_SHOW: begin
                if (empty_now) begin
                  data_value <= '0;
                  top_value  <= '0;
                  status     <= ST_EMPTY;
                  is_empty   <= 1'b1;
                  is_full    <= full_now;
                  last       <= 1'b1;
                end else if (q_item.op == OP_POP) begin
                  state <= S_POP_RD;
                end else begin
                  idx   <= cnt_m1[AW-1:0];
                  state <= S_SHOW_RD;
                end
              end
              default: begin
                data_value <= '0;
                top_value  <= top_cur;
                status     <= ST_DONE;
                is_empty   <= empty_now;
                is_full    <= full_now;
                last       <= 1'b1;
              end
            endcase
          end
        end
        S_POP_RD: begin
          if (can_load) begin
            data_value <= top;
            top_value  <= (cnt_m1 == '0) ? '0 : rd_data;
            status     <= ST_DONE;
            is_empty   <= (cnt_m1 == '0);
            is_full    <= full_dec;
            last       <= 1'b1;
            count      <= cnt_m1;
            top        <= rd_data;
            state      <= S_IDLE;
          end
        end
        S_SHOW_RD: begin
          state <= S_SHOW_EMIT;
        end
        S_SHOW_EMIT: begin
          if (can_load) begin
            data_value <= rd_data;
            top_value  <= top_cur;
            status     <= ST_DONE;
            is_empty   <= 1'b0;
            is_full    <= full_now;
            last       <= (idx == '0);
            if (idx == '0) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx - AW'(1);
              state <= S_SHOW_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/blstk_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blstk_checker
// Port-level checks on the result channel of the stack.
// ----------------------------------------------------------------------------
module blstk_checker import blstk_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [WORD_W-1:0] data_value,
  input logic signed [WORD_W-1:0] top_value,
  input logic [1:0]               status,
  input logic                     is_empty,
  input logic                     is_full,
  input logic                     last
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_value) && $stable(top_value)
      && $stable(status) && $stable(last))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> top_value == '0 && !is_full)
    else $error("empty stack with nonzero top or full flag");

  a_refused_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> is_empty && data_value == '0 && last)
    else $error("empty status inconsistent");

  a_refused_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> is_full && data_value == '0 && last)
    else $error("full status inconsistent");

endmodule

bind bounded_lifo_stack blstk_checker u_blstk_checker (.*);

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded lifo stack. A directed table of
// commands and capacity writes runs first, then four random phases with
// different sender and receiver idling. Every accepted result is compared
// field by field against a bench stack predictor or a typed table row.
// ----------------------------------------------------------------------------
module testbench;
  import blstk_pkg::*;

  localparam int unsigned DEPTH          = 64;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned HOLD_CYCLES    = 250;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    logic signed [WORD_W-1:0] top;
    logic [1:0]               status;
    logic                     empty;
    logic                     full;
    logic                     last;
  } stack_result_t;

  typedef struct {
    bit                is_cfg;
    op_t               op;
    logic [WORD_W-1:0] value;
    logic [CAP_W-1:0]  cap;
    bit                typed;
    stack_result_t     res;
  } stim_row_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_wen;
  logic [CAP_W-1:0]         cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               cmd;
  logic signed [WORD_W-1:0] push_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [WORD_W-1:0] data_value;
  logic signed [WORD_W-1:0] top_value;
  logic [1:0]               status;
  logic                     is_empty;
  logic                     is_full;
  logic                     last;

  // stack predictor state
  logic signed [WORD_W-1:0] stack_mem [DEPTH];
  int unsigned              stack_count;
  logic [CAP_W-1:0]         cap_reg;
  stack_result_t            expected_results [$];

  int unsigned mismatch_count;
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned idle_cycles;
  bit          hold_req;
  bit          hold_done;
  int unsigned hold_left;

  bounded_lifo_stack #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .push_value(push_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data_value(data_value),
    .top_value (top_value),
    .status    (status),
    .is_empty  (is_empty),
    .is_full   (is_full),
    .last      (last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                             input logic [WORD_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    end
  endtask

  function automatic int unsigned cap_limit();
    int unsigned c;
    c = cap_reg;
    if (c < 1) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic stack_result_t make_result(input logic signed [WORD_W-1:0] d,
                                                input logic [1:0] st, input logic lst);
    stack_result_t r;
    r.data   = d;
    r.status = st;
    r.last   = lst;
    r.empty  = (stack_count == 0);
    r.top    = r.empty ? '0 : stack_mem[stack_count-1];
    r.full   = (stack_count >= cap_limit());
    return r;
  endfunction

  task automatic predict_stack(input op_t op, input logic signed [WORD_W-1:0] v,
                               input bit typed, input stack_result_t typed_res);
    stack_result_t res_q [$];
    int unsigned   i;
    case (op)
      OP_PUSH: begin
        if (stack_count >= cap_limit()) begin
          res_q.push_back(make_result('0, ST_FULL, 1'b1));
        end else begin
          stack_mem[stack_count] = v;
          stack_count++;
          res_q.push_back(make_result('0, ST_DONE, 1'b1));
        end
      end
      OP_POP: begin
        if (stack_count == 0) begin
          res_q.push_back(make_result('0, ST_EMPTY, 1'b1));
        end else begin
          stack_count--;
          res_q.push_back(make_result(stack_mem[stack_count], ST_DONE, 1'b1));
        end
      end
      OP_SHOW: begin
        if (stack_count == 0) begin
          res_q.push_back(make_result('0, ST_EMPTY, 1'b1));
        end else begin
          for (i = stack_count; i > 0; i--) begin
            res_q.push_back(make_result(stack_mem[i-1], ST_DONE, i == 1));
          end
        end
      end
      default: begin
        res_q.push_back(make_result('0, ST_DONE, 1'b1));
      end
    endcase
    if (typed) begin
      expected_results.push_back(typed_res);
    end else begin
      foreach (res_q[k]) expected_results.push_back(res_q[k]);
    end
  endtask

  task automatic send_item(input op_t op, input logic [WORD_W-1:0] v,
                           input bit typed, input stack_result_t typed_res);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= op;
    push_value <= v;
    do @(posedge clk); while (in_stall);
    predict_stack(op, v, typed, typed_res);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    drain_results();
    cfg_wen   <= 1'b1;
    cfg_wdata <= c;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    cap_reg = c;
  endtask

  function automatic stim_row_t item_row(input op_t op, input logic [WORD_W-1:0] v);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.op     = op;
    r.value  = v;
    r.cap    = '0;
    r.typed  = 1'b0;
    r.res    = '0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input op_t op, input logic [WORD_W-1:0] v,
                                          input stack_result_t res);
    stim_row_t r;
    r       = item_row(op, v);
    r.typed = 1'b1;
    r.res   = res;
    return r;
  endfunction

  function automatic stim_row_t cap_row(input logic [CAP_W-1:0] c);
    stim_row_t r;
    r        = item_row(OP_NOP, '0);
    r.is_cfg = 1'b1;
    r.cap    = c;
    return r;
  endfunction

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    stack_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        want = expected_results.pop_front();
        check_field("data_value", data_value, want.data);
        check_field("top_value", top_value, want.top);
        check_field("status", {30'd0, status}, {30'd0, want.status});
        check_field("is_empty", {31'd0, is_empty}, {31'd0, want.empty});
        check_field("is_full", {31'd0, is_full}, {31'd0, want.full});
        check_field("last", {31'd0, last}, {31'd0, want.last});
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wen) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t        rows [$];
    stack_result_t    no_res;
    int unsigned      ph;
    int unsigned      n;
    int unsigned      items;
    int unsigned      push_w;
    int unsigned      pop_w;
    int unsigned      show_w;
    int unsigned      r;
    op_t              op;
    logic [CAP_W-1:0] cap;

    rst            = 1'b1;
    cfg_wen        = 1'b0;
    cfg_wdata      = CAP_RESET;
    in_valid       = 1'b0;
    cmd            = OP_PUSH;
    push_value     = '0;
    in_idle_pct    = 0;
    out_stall_pct  = 0;
    hold_req       = 1'b0;
    mismatch_count = 0;
    stack_count    = 0;
    cap_reg        = CAP_RESET;
    no_res         = '0;
    foreach (stack_mem[k]) stack_mem[k] = '0;

    // directed table
    rows.push_back(typed_row(OP_POP, '0, '{'0, '0, ST_EMPTY, 1'b1, 1'b0, 1'b1}));
    rows.push_back(typed_row(OP_SHOW, '0, '{'0, '0, ST_EMPTY, 1'b1, 1'b0, 1'b1}));
    rows.push_back(typed_row(OP_NOP, '0, '{'0, '0, ST_DONE, 1'b1, 1'b0, 1'b1}));
    rows.push_back(typed_row(OP_PUSH, 32'h7FFF_FFFF,
                             '{'0, 32'h7FFF_FFFF, ST_DONE, 1'b0, 1'b0, 1'b1}));
    rows.push_back(typed_row(OP_PUSH, 32'h8000_0000,
                             '{'0, 32'h8000_0000, ST_DONE, 1'b0, 1'b0, 1'b1}));
    rows.push_back(typed_row(OP_PUSH, 32'hFFFF_FFFF,
                             '{'0, 32'hFFFF_FFFF, ST_DONE, 1'b0, 1'b0, 1'b1}));
    rows.push_back(item_row(OP_PUSH, 32'h0000_0000));
    rows.push_back(item_row(OP_SHOW, '0));
    rows.push_back(item_row(OP_NOP, 32'h1234_5678));
    rows.push_back(item_row(OP_POP, '0));
    // capacity below the stored count
    rows.push_back(cap_row(7'd1));
    rows.push_back(typed_row(OP_PUSH, 32'h5A5A_5A5A,
                             '{'0, 32'hFFFF_FFFF, ST_FULL, 1'b0, 1'b1, 1'b1}));
    rows.push_back(item_row(OP_POP, '0));
    // zero capacity acts as one
    rows.push_back(cap_row(7'd0));
    rows.push_back(item_row(OP_POP, '0));
    rows.push_back(item_row(OP_POP, '0));
    rows.push_back(item_row(OP_POP, '0));
    rows.push_back(item_row(OP_PUSH, 32'h0000_0001));
    rows.push_back(typed_row(OP_PUSH, 32'h0000_0002,
                             '{'0, 32'h0000_0001, ST_FULL, 1'b0, 1'b1, 1'b1}));
    // oversized capacity clamps to depth
    rows.push_back(cap_row(7'd127));
    rows.push_back(item_row(OP_PUSH, 32'hAAAA_AAAA));
    rows.push_back(item_row(OP_PUSH, 32'h5555_5555));
    rows.push_back(item_row(OP_SHOW, '0));
    rows.push_back(item_row(OP_POP, '0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[k]) begin
      if (rows[k].is_cfg) begin
        write_capacity(rows[k].cap);
      end else begin
        send_item(rows[k].op, rows[k].value, rows[k].typed, rows[k].res);
      end
    end

    // random phases
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          in_idle_pct = 0;  out_stall_pct = 0;
          cap = CAP_RESET;
          items = 70; push_w = 90; pop_w = 5; show_w = 3;
        end
        1: begin
          in_idle_pct = 48; out_stall_pct = 0;
          cap = $urandom_range(1, 8);
          items = 40; push_w = 35; pop_w = 45; show_w = 10;
        end
        2: begin
          in_idle_pct = 0;  out_stall_pct = 48;
          cap = $urandom_range(9, 40);
          items = 40; push_w = 35; pop_w = 45; show_w = 10;
        end
        default: begin
          in_idle_pct = 28; out_stall_pct = 28;
          cap = $urandom_range(65, 127);
          items = 40; push_w = 40; pop_w = 40; show_w = 10;
        end
      endcase
      write_capacity(cap);
      // long receiver hold-off while items keep coming
      if (ph == 0) hold_req = 1'b1;
      for (n = 0; n < items; n++) begin
        r = $urandom_range(99);
        if (r < push_w) op = OP_PUSH;
        else if (r < push_w + pop_w) op = OP_POP;
        else if (r < push_w + pop_w + show_w) op = OP_SHOW;
        else op = OP_NOP;
        send_item(op, $urandom, 1'b0, no_res);
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
